>>> rtl/core/spu_pkg.sv
package spu_pkg;

    localparam int IDX_W  = 11;
    localparam int CTR_W  = 24;
    localparam int VEL_W  = 16;
    localparam int CRN_W  = 21;
    localparam int TRG_W  = 16;
    localparam int PIX_W  = 16;
    localparam int PROD_W = CRN_W + TRG_W;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } t_cmd;

    typedef enum logic {
        CFG_GRAVITY   = 1'b0,
        CFG_HALF_SIDE = 1'b1
    } t_cfg_idx;

    localparam logic [7:0] GRAVITY_RESET   = 8'd26;
    localparam logic [6:0] HALF_SIDE_RESET = 7'd10;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         shard_index;
        logic signed [CTR_W-1:0]  center_x;
        logic signed [CTR_W-1:0]  center_y;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic                     triangle_kind;
        logic signed [TRG_W-1:0]  cos_first;
        logic signed [TRG_W-1:0]  sin_first;
        logic signed [TRG_W-1:0]  cos_second;
        logic signed [TRG_W-1:0]  sin_second;
    } t_in_item;

    typedef struct packed {
        logic signed [PIX_W-1:0] screen_x;
        logic signed [PIX_W-1:0] screen_y;
        logic [1:0]              corner_slot;
        logic                    last_corner;
    } t_out_item;

    typedef struct packed {
        logic signed [CRN_W-1:0] x;
        logic signed [CRN_W-1:0] y;
        logic signed [CRN_W-1:0] z;
    } t_corner;

    typedef struct packed {
        logic signed [CTR_W-1:0] x;
        logic signed [CTR_W-1:0] y;
    } t_center;

    typedef struct packed {
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
    } t_vel;

    typedef struct packed {
        logic signed [TRG_W-1:0] c1;
        logic signed [TRG_W-1:0] s1;
        logic signed [TRG_W-1:0] c2;
        logic signed [TRG_W-1:0] s2;
    } t_rot;

    // Round a Q.22 product sum half up to Q.8 and clamp to the corner range
    function automatic logic signed [CRN_W-1:0] rot_round(input logic signed [PROD_W:0] p);
        logic signed [PROD_W+1:0] r;
        logic [PROD_W-13:0]       q;
        logic [PROD_W-13:0]       top;
        begin
            r   = {p[PROD_W], p} + (PROD_W+2)'(8192);
            q   = r[PROD_W+1:14];
            top = q >> (CRN_W - 1);
            if ((&q[PROD_W-13:CRN_W-1]) || !(|top)) begin
                rot_round = q[CRN_W-1:0];
            end else if (q[PROD_W-13]) begin
                rot_round = {1'b1, {(CRN_W-1){1'b0}}};
            end else begin
                rot_round = {1'b0, {(CRN_W-1){1'b1}}};
            end
        end
    endfunction

    function automatic logic signed [CTR_W-1:0] sat_center(input logic signed [CTR_W:0] s);
        begin
            if (s[CTR_W] == s[CTR_W-1]) begin
                sat_center = s[CTR_W-1:0];
            end else if (s[CTR_W]) begin
                sat_center = {1'b1, {(CTR_W-1){1'b0}}};
            end else begin
                sat_center = {1'b0, {(CTR_W-1){1'b1}}};
            end
        end
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W:0] s);
        begin
            if (s[VEL_W] == s[VEL_W-1]) begin
                sat_vel = s[VEL_W-1:0];
            end else if (s[VEL_W]) begin
                sat_vel = {1'b1, {(VEL_W-1){1'b0}}};
            end else begin
                sat_vel = {1'b0, {(VEL_W-1){1'b1}}};
            end
        end
    endfunction

    // Center plus corner in Q.8, truncated toward zero to pixels, clamped to 16 bits
    function automatic logic signed [PIX_W-1:0] to_pixel(input logic signed [CTR_W-1:0] c,
                                                         input logic signed [CRN_W-1:0] k);
        logic signed [CTR_W:0]   s;
        logic signed [CTR_W:0]   t;
        logic [CTR_W-8:0]        q;
        begin
            s = {c[CTR_W-1], c} + (CTR_W+1)'(k);
            t = s[CTR_W] ? s + (CTR_W+1)'(255) : s;
            q = t[CTR_W:8];
            if (q[CTR_W-8] == q[PIX_W-1] && (&q[CTR_W-8:PIX_W-1] || !(|q[CTR_W-8:PIX_W-1])))
            begin
                to_pixel = q[PIX_W-1:0];
            end else if (q[CTR_W-8]) begin
                to_pixel = {1'b1, {(PIX_W-1){1'b0}}};
            end else begin
                to_pixel = {1'b0, {(PIX_W-1){1'b1}}};
            end
        end
    endfunction

endpackage

>>> rtl/core/shard_particle_update_unit.sv
// A new shard can be taken as the previous one issues its last corner. The output port
// emits one corner per cycle while the receiver is ready, and a shard entry is read once
// and written back three times from the table.
// A shard that is still in the update pipeline holds off a new transaction on it.
// Reset clears control and presets config; shard tables hold no value until loaded.
module shard_particle_update_unit
    import spu_pkg::*;
#(
    parameter int SHARD_COUNT = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int AW       = (SHARD_COUNT > 1) ? $clog2(SHARD_COUNT) : 1;
    localparam int FDEPTH   = 16;
    localparam int FAW      = 4;
    localparam int CNT_W    = 5;

    typedef struct packed {
        logic                     v;
        logic                     cmd;
        logic [AW-1:0]            addr;
        logic [1:0]               k;
        t_center                  ctr;
        t_vel                     vel;
        logic signed [CRN_W-1:0]  x;
        logic signed [CRN_W-1:0]  y;
        logic signed [TRG_W-1:0]  c2;
        logic signed [TRG_W-1:0]  s2;
    } t_ctl;

    // shard tables
    t_center m_center [SHARD_COUNT];
    t_vel    m_vel    [SHARD_COUNT];
    t_rot    m_rot    [SHARD_COUNT];
    t_corner m_crn0   [SHARD_COUNT];
    t_corner m_crn1   [SHARD_COUNT];
    t_corner m_crn2   [SHARD_COUNT];

    logic [7:0] r_gravity;
    logic [6:0] r_half;

    logic          w_in_acc;
    logic          w_in_range;
    logic [AW-1:0] w_in_addr;
    logic          w_hazard;
    logic          w_out_acc;

    // current shard being issued
    t_in_item      r_it;
    logic [AW-1:0] r_ph_addr;
    logic          r_ph_act;
    logic [1:0]    r_ph_k;
    t_center       r_rd_ctr;
    t_vel          r_rd_vel;
    t_rot          r_rd_rot;
    t_corner       r_rd_crn0;
    t_corner       r_rd_crn1;
    t_corner       r_rd_crn2;

    t_ctl r_s1, r_s2, r_s3, r_s4;
    t_ctl w_s1;
    logic signed [PROD_W-1:0] r_p1_xc, r_p1_zs, r_p1_zc, r_p1_xs;
    logic signed [PROD_W-1:0] w_p1_xc, w_p1_zs, w_p1_zc, w_p1_xs;
    logic signed [CRN_W-1:0]  r_s2_nx, r_s2_nz;
    logic signed [CRN_W-1:0]  r_s3_nx;
    logic signed [PROD_W-1:0] r_p3_yc, r_p3_zs, r_p3_zc, r_p3_ys;
    t_corner                  r_s4_crn;
    t_corner                  w_s4_crn;

    t_corner                  w_sel_crn;
    t_corner                  w_load_crn;
    logic signed [CRN_W-1:0]  w_h;

    t_out_item        r_fifo [FDEPTH];
    logic [FAW-1:0]   r_wp, r_rp;
    logic [CNT_W-1:0] r_fcnt, n_fcnt;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_out_item        w_push;

    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RESET;
            r_half    <= HALF_SIDE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRAVITY:   r_gravity <= i_cfg_data;
                CFG_HALF_SIDE: r_half    <= i_cfg_data[6:0];
                default:       r_gravity <= r_gravity;
            endcase
        end
    end

    // accept control
    assign w_in_range = (32'(i_in_data.shard_index) < SHARD_COUNT);
    assign w_in_addr  = AW'(i_in_data.shard_index);
    assign w_hazard   = (r_ph_act && r_ph_addr == w_in_addr)
                     || (r_s1.v && r_s1.addr == w_in_addr)
                     || (r_s2.v && r_s2.addr == w_in_addr)
                     || (r_s3.v && r_s3.addr == w_in_addr)
                     || (r_s4.v && r_s4.addr == w_in_addr);
    assign o_in_ready = (!r_ph_act || r_ph_k == 2'd2)
                     && (r_cnt <= CNT_W'(FDEPTH - 3)) && !w_hazard;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // issue sequencer: one corner per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_act <= 1'b0;
            r_ph_k   <= 2'd0;
        end else if (w_in_acc && w_in_range) begin
            r_ph_act <= 1'b1;
            r_ph_k   <= 2'd0;
        end else if (r_ph_act) begin
            r_ph_act <= (r_ph_k != 2'd2);
            r_ph_k   <= r_ph_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_it      <= i_in_data;
            r_ph_addr <= w_in_addr;
        end
    end

    // table read on accept, rotation written on load
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_in_range) begin
            r_rd_ctr  <= m_center[w_in_addr];
            r_rd_vel  <= m_vel[w_in_addr];
            r_rd_rot  <= m_rot[w_in_addr];
            r_rd_crn0 <= m_crn0[w_in_addr];
            r_rd_crn1 <= m_crn1[w_in_addr];
            r_rd_crn2 <= m_crn2[w_in_addr];
            if (i_in_data.cmd == CMD_LOAD) begin
                m_rot[w_in_addr] <= {i_in_data.cos_first, i_in_data.sin_first,
                                     i_in_data.cos_second, i_in_data.sin_second};
            end
        end
    end

    // select corner and form first rotation products
    assign w_h = CRN_W'({r_half, 8'd0});

    always_comb begin
        case (r_ph_k)
            2'd0:    w_sel_crn = r_rd_crn0;
            2'd1:    w_sel_crn = r_rd_crn1;
            default: w_sel_crn = r_rd_crn2;
        endcase
        w_load_crn.z = '0;
        if (r_ph_k == 2'd2 || (r_ph_k == 2'd1 && r_it.triangle_kind)) begin
            w_load_crn.y = w_h;
        end else begin
            w_load_crn.y = -w_h;
        end
        if (r_ph_k == 2'd2 || (r_ph_k == 2'd0 && !r_it.triangle_kind)) begin
            w_load_crn.x = -w_h;
        end else begin
            w_load_crn.x = w_h;
        end

        w_s1.v    = r_ph_act;
        w_s1.cmd  = r_it.cmd;
        w_s1.addr = r_ph_addr;
        w_s1.k    = r_ph_k;
        w_s1.c2   = r_rd_rot.c2;
        w_s1.s2   = r_rd_rot.s2;
        if (r_it.cmd == CMD_LOAD) begin
            w_s1.ctr = {r_it.center_x, r_it.center_y};
            w_s1.vel = {r_it.vel_x, r_it.vel_y};
            w_s1.x   = w_load_crn.x;
            w_s1.y   = w_load_crn.y;
        end else begin
            w_s1.ctr.x = sat_center({r_rd_ctr.x[CTR_W-1], r_rd_ctr.x}
                                    + (CTR_W+1)'(r_rd_vel.x));
            w_s1.ctr.y = sat_center({r_rd_ctr.y[CTR_W-1], r_rd_ctr.y}
                                    + (CTR_W+1)'(r_rd_vel.y));
            w_s1.vel.x = r_rd_vel.x;
            w_s1.vel.y = sat_vel({r_rd_vel.y[VEL_W-1], r_rd_vel.y}
                                 + (VEL_W+1)'(r_gravity));
            w_s1.x     = w_sel_crn.x;
            w_s1.y     = w_sel_crn.y;
        end
        w_p1_xc = w_sel_crn.x * r_rd_rot.c1;
        w_p1_zs = w_sel_crn.z * r_rd_rot.s1;
        w_p1_zc = w_sel_crn.z * r_rd_rot.c1;
        w_p1_xs = w_sel_crn.x * r_rd_rot.s1;
    end

    // update pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.v <= 1'b0;
            r_s2.v <= 1'b0;
            r_s3.v <= 1'b0;
            r_s4.v <= 1'b0;
        end else begin
            r_s1.v <= w_s1.v;
            r_s2.v <= r_s1.v;
            r_s3.v <= r_s2.v;
            r_s4.v <= r_s3.v;
        end

        r_s1[$bits(t_ctl)-2:0] <= w_s1[$bits(t_ctl)-2:0];
        r_p1_xc <= w_p1_xc;
        r_p1_zs <= w_p1_zs;
        r_p1_zc <= w_p1_zc;
        r_p1_xs <= w_p1_xs;

        // round the x-z rotation
        r_s2[$bits(t_ctl)-2:0] <= r_s1[$bits(t_ctl)-2:0];
        r_s2_nx <= rot_round({r_p1_xc[PROD_W-1], r_p1_xc} - {r_p1_zs[PROD_W-1], r_p1_zs});
        r_s2_nz <= rot_round({r_p1_zc[PROD_W-1], r_p1_zc} + {r_p1_xs[PROD_W-1], r_p1_xs});

        // y-z products on the updated z
        r_s3[$bits(t_ctl)-2:0] <= r_s2[$bits(t_ctl)-2:0];
        r_s3_nx <= r_s2_nx;
        r_p3_yc <= r_s2.y * r_s2.c2;
        r_p3_zs <= r_s2_nz * r_s2.s2;
        r_p3_zc <= r_s2_nz * r_s2.c2;
        r_p3_ys <= r_s2.y * r_s2.s2;

        // round the y-z rotation, keep load corners as given
        r_s4[$bits(t_ctl)-2:0] <= r_s3[$bits(t_ctl)-2:0];
        r_s4_crn <= w_s4_crn;
    end

    always_comb begin
        if (r_s3.cmd == CMD_LOAD) begin
            w_s4_crn.x = r_s3.x;
            w_s4_crn.y = r_s3.y;
            w_s4_crn.z = '0;
        end else begin
            w_s4_crn.x = r_s3_nx;
            w_s4_crn.y = rot_round({r_p3_yc[PROD_W-1], r_p3_yc}
                                   - {r_p3_zs[PROD_W-1], r_p3_zs});
            w_s4_crn.z = rot_round({r_p3_zc[PROD_W-1], r_p3_zc}
                                   + {r_p3_ys[PROD_W-1], r_p3_ys});
        end
    end

    // write back the shard
    always_ff @(posedge i_clk) begin
        if (r_s4.v) begin
            m_center[r_s4.addr] <= r_s4.ctr;
            m_vel[r_s4.addr]    <= r_s4.vel;
            case (r_s4.k)
                2'd0:    m_crn0[r_s4.addr] <= r_s4_crn;
                2'd1:    m_crn1[r_s4.addr] <= r_s4_crn;
                default: m_crn2[r_s4.addr] <= r_s4_crn;
            endcase
        end
    end

    // screen position into the output queue
    always_comb begin
        w_push.screen_x    = to_pixel(r_s4.ctr.x, r_s4_crn.x);
        w_push.screen_y    = to_pixel(r_s4.ctr.y, r_s4_crn.y);
        w_push.corner_slot = r_s4.k;
        w_push.last_corner = (r_s4.k == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (r_s4.v) begin
            r_fifo[r_wp] <= w_push;
        end
    end

    assign o_out_valid = (r_fcnt != '0);
    assign o_out_data  = r_fifo[r_rp];
    assign w_out_acc   = o_out_valid && i_out_ready;

    always_comb begin
        n_fcnt = r_fcnt + CNT_W'(r_s4.v) - CNT_W'(w_out_acc);
        n_cnt  = r_cnt + ((w_in_acc && w_in_range) ? CNT_W'(3) : '0) - CNT_W'(w_out_acc);
    end

    // queue pointers and result credits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
            r_cnt  <= '0;
        end else begin
            if (r_s4.v) begin
                r_wp <= r_wp + FAW'(1);
            end
            if (w_out_acc) begin
                r_rp <= r_rp + FAW'(1);
            end
            r_fcnt <= n_fcnt;
            r_cnt  <= n_cnt;
        end
    end

endmodule

>>> bench/spu_checker.sv
`timescale 1ns / 100ps

// Watches the load/step, corner and register channels, predicts each corner and compares.
module spu_checker
    import spu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending
);

    localparam int SHARDS = 2048;

    // Own copy of the shard table and the registers
    t_center    centers [SHARDS];
    t_vel       vels    [SHARDS];
    t_rot       rots    [SHARDS];
    t_corner    corners [SHARDS][3];
    logic [7:0] gravity;
    logic [6:0] half_side;

    t_out_item  corner_queue[$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Round half up from Q.22 to Q.8, then clamp to the corner range
    function automatic longint corner_round(longint p);
        return clamp((p + 8192) >>> 14, -1048576, 1048575);
    endfunction

    // Queue the three corner positions of one shard
    function automatic void push_corners(int idx);
        t_out_item e;
        longint    sx;
        longint    sy;
        for (int k = 0; k < 3; k++) begin
            sx = longint'(centers[idx].x) + longint'(corners[idx][k].x);
            sy = longint'(centers[idx].y) + longint'(corners[idx][k].y);
            e.screen_x    = 16'(clamp(sx / 256, -32768, 32767));
            e.screen_y    = 16'(clamp(sy / 256, -32768, 32767));
            e.corner_slot = 2'(k);
            e.last_corner = (k == 2);
            corner_queue.push_back(e);
        end
    endfunction

    // Apply one load or step transaction to the table
    function automatic void update_shard(t_in_item it);
        int     idx;
        longint h;
        longint x, y, z, nx, ny, nz;
        longint c1, s1, c2, s2;
        idx = int'(it.shard_index);
        if (it.cmd == CMD_LOAD) begin
            h = longint'(half_side) * 256;
            centers[idx].x = it.center_x;
            centers[idx].y = it.center_y;
            vels[idx].x    = it.vel_x;
            vels[idx].y    = it.vel_y;
            rots[idx].c1   = it.cos_first;
            rots[idx].s1   = it.sin_first;
            rots[idx].c2   = it.cos_second;
            rots[idx].s2   = it.sin_second;
            if (it.triangle_kind == 1'b0) begin
                corners[idx][0].x = 21'(-h); corners[idx][0].y = 21'(-h);
                corners[idx][1].x = 21'(h);  corners[idx][1].y = 21'(-h);
            end else begin
                corners[idx][0].x = 21'(h);  corners[idx][0].y = 21'(-h);
                corners[idx][1].x = 21'(h);  corners[idx][1].y = 21'(h);
            end
            corners[idx][2].x = 21'(-h);
            corners[idx][2].y = 21'(h);
            for (int k = 0; k < 3; k++) corners[idx][k].z = '0;
        end else begin
            centers[idx].x = 24'(clamp(longint'(centers[idx].x) + longint'(vels[idx].x),
                                       -8388608, 8388607));
            centers[idx].y = 24'(clamp(longint'(centers[idx].y) + longint'(vels[idx].y),
                                       -8388608, 8388607));
            vels[idx].y = 16'(clamp(longint'(vels[idx].y) + longint'(gravity), -32768, 32767));
            c1 = rots[idx].c1; s1 = rots[idx].s1;
            c2 = rots[idx].c2; s2 = rots[idx].s2;
            for (int k = 0; k < 3; k++) begin
                x  = corners[idx][k].x;
                y  = corners[idx][k].y;
                z  = corners[idx][k].z;
                nx = corner_round(x * c1 - z * s1);
                nz = corner_round(z * c1 + x * s1);
                ny = corner_round(y * c2 - nz * s2);
                nz = corner_round(nz * c2 + y * s2);
                corners[idx][k].x = 21'(nx);
                corners[idx][k].y = 21'(ny);
                corners[idx][k].z = 21'(nz);
            end
        end
        push_corners(idx);
    endfunction

    assign o_pending = corner_queue.size();

    // Track registers, predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            gravity   <= GRAVITY_RESET;
            half_side <= HALF_SIDE_RESET;
            o_errors  <= 0;
            corner_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_GRAVITY) gravity <= i_cfg_data;
                else half_side <= i_cfg_data[6:0];
            end
            if (i_in_valid && i_in_ready) update_shard(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (corner_queue.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected corner x=%0d y=%0d slot=%0d last=%0d",
                                 i_out_data.screen_x, i_out_data.screen_y,
                                 i_out_data.corner_slot, i_out_data.last_corner);
                    o_errors <= o_errors + 1;
                end else begin
                    want = corner_queue.pop_front();
                    if (i_out_data.screen_x !== want.screen_x ||
                        i_out_data.screen_y !== want.screen_y ||
                        i_out_data.corner_slot !== want.corner_slot ||
                        i_out_data.last_corner !== want.last_corner) begin
                        if (o_errors < 10)
                            $display("corner mismatch: exp x=%0d y=%0d slot=%0d last=%0d, got x=%0d y=%0d slot=%0d last=%0d",
                                     want.screen_x, want.screen_y, want.corner_slot,
                                     want.last_corner, i_out_data.screen_x,
                                     i_out_data.screen_y, i_out_data.corner_slot,
                                     i_out_data.last_corner);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import spu_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_data;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;
    int         errors;
    int         pending;

    bit         loaded [2048];
    int         sent;
    bit         no_idle;
    bit         hold_done;
    longint     cycles;

    shard_particle_update_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    spu_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly short gaps, a few long ones, none during a burst
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Offer one transaction and hold it until the block takes it
    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        loaded[it.shard_index] = 1'b1;
        sent++;
    endtask

    // Drain, let the pipeline settle, then write one register
    task automatic write_reg(t_cfg_idx idx, logic [7:0] value);
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_trig();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
        if (r == 7) return 16'(16384);
        return 16'($urandom());
    endfunction

    function automatic t_in_item make_load(int idx);
        t_in_item it;
        it.cmd           = CMD_LOAD;
        it.shard_index   = 11'(idx);
        it.center_x      = 24'($urandom());
        it.center_y      = 24'($urandom());
        it.vel_x         = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2047) - 1024);
        it.vel_y         = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2047) - 1024);
        it.triangle_kind = 1'($urandom());
        it.cos_first     = pick_trig();
        it.sin_first     = pick_trig();
        it.cos_second    = pick_trig();
        it.sin_second    = pick_trig();
        return it;
    endfunction

    function automatic t_in_item make_step(int idx);
        t_in_item it;
        it             = make_load(idx);
        it.cmd         = CMD_STEP;
        return it;
    endfunction

    // Random mix over a few busy shards and the whole table
    task automatic run_random(int count);
        int idx;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 5);
            if (!loaded[idx] || $urandom_range(0, 2) == 0) send_item(make_load(idx));
            else send_item(make_step(idx));
        end
        no_idle = 1'b0;
    endtask

    // Receiver: random stalls, and one long hold-off once traffic is flowing
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!hold_done && sent >= 120) begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_done = 1'b1;
            end else if (pick_gap() > 0) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_in_item it;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GRAVITY;
        cfg_data  = '0;
        sent      = 0;
        no_idle   = 1'b0;
        hold_done = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed: field extremes, both kinds, steps with saturation
        it = make_load(0);
        it.center_x = 24'sh7FFFFF; it.center_y = 24'sh7FFFFF;
        it.vel_x = 16'sh7FFF; it.vel_y = 16'sh7FFF; it.triangle_kind = 1'b0;
        it.cos_first = 16'sd16384; it.sin_first = 16'sd0;
        it.cos_second = 16'sd16384; it.sin_second = 16'sd0;
        send_item(it);
        it = make_load(2047);
        it.center_x = 24'sh800000; it.center_y = 24'sh800000;
        it.vel_x = 16'sh8000; it.vel_y = 16'sh8000; it.triangle_kind = 1'b1;
        it.cos_first = -16'sd16384; it.sin_first = 16'sd16384;
        it.cos_second = 16'sd0; it.sin_second = -16'sd16384;
        send_item(it);
        it = make_load(1);
        it.center_x = 24'd0; it.center_y = 24'd0;
        it.cos_first = 16'sh7FFF; it.sin_first = 16'sh8000;
        it.cos_second = 16'sh8000; it.sin_second = 16'sh7FFF;
        send_item(it);
        for (int n = 0; n < 4; n++) begin
            send_item(make_step(0));
            send_item(make_step(2047));
            send_item(make_step(1));
        end
        run_random(60);

        // Register extremes, half side zero among them
        write_reg(CFG_GRAVITY, 8'd0);
        write_reg(CFG_HALF_SIDE, 8'd0);
        send_item(make_load(0));
        send_item(make_step(0));
        run_random(60);
        write_reg(CFG_GRAVITY, 8'd255);
        write_reg(CFG_HALF_SIDE, 8'd127);
        run_random(90);
        write_reg(CFG_GRAVITY, 8'($urandom()));
        write_reg(CFG_HALF_SIDE, 8'($urandom_range(1, 127)));
        run_random(80);
        write_reg(CFG_GRAVITY, 8'd26);
        write_reg(CFG_HALF_SIDE, 8'd1);
        run_random(40);
        @(negedge clk) in_valid <= 1'b0;

        // Drain and settle
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/spu_pkg.sv
rtl/core/shard_particle_update_unit.sv
bench/spu_checker.sv
bench/tb.sv
